// ===== hdl/dbc_pkg.sv =====
// dbc_pkg: shared types and constants of the directory block checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dbc_pkg;

  localparam logic [15:0] TAIL_BYTES     = 16'd12;
  localparam logic [15:0] HDR_BYTES      = 16'd8;
  localparam logic [15:0] MIN_TAIL_BLOCK = 16'd20;
  localparam logic [7:0]  TAIL_TYPE      = 8'hDE;
  localparam logic [7:0]  DOT_CHAR       = 8'h2E;
  localparam logic [15:0] BLOCK_SIZE_RST = 16'd4096;

  localparam logic CFG_BLOCK_SIZE   = 1'b0;
  localparam logic CFG_TAIL_PRESENT = 1'b1;

  typedef enum logic [2:0] {
    FAULT_NONE    = 3'd0,
    FAULT_SMALL   = 3'd1,
    FAULT_REC_LEN = 3'd2,
    FAULT_NAME    = 3'd3,
    FAULT_TAIL    = 3'd4
  } fault_e;

  typedef struct packed {
    logic [15:0] blk_len;
    logic        tail_present;
    logic        too_small;
    logic [15:0] usable;
  } cfg_t;

  typedef struct packed {
    logic       block_ok;
    logic [2:0] fault_kind;
    logic       only_dot_entries;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/dbc_if.sv =====
// dbc_if: valid/ready channels for block bytes and check results
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface dbc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface dbc_res_if;
  logic       valid;
  logic       ready;
  logic       block_ok;
  logic [2:0] fault_kind;
  logic       only_dot_entries;

  modport source (output valid, output block_ok, output fault_kind,
                  output only_dot_entries, input ready);
  modport sink (input valid, input block_ok, input fault_kind,
                input only_dot_entries, output ready);
endinterface

`default_nettype wire

// ===== hdl/dbc_cfg_regs.sv =====
// dbc_cfg_regs: block size and tail registers with derived usable area
// depends on dbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbc_cfg_regs
  import dbc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  logic [15:0] blk_len_q;
  logic        tail_q;
  logic        too_small;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_len_q <= BLOCK_SIZE_RST;
      tail_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_SIZE:   blk_len_q <= cfg_wdata_i;
        CFG_TAIL_PRESENT: tail_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign too_small = (blk_len_q < HDR_BYTES) ||
                     (tail_q && (blk_len_q < MIN_TAIL_BLOCK));

  always_comb begin
    cfg_o.blk_len      = blk_len_q;
    cfg_o.tail_present = tail_q;
    cfg_o.too_small    = too_small;
    if (too_small) begin
      cfg_o.usable = 16'd0;
    end else if (tail_q) begin
      cfg_o.usable = blk_len_q - TAIL_BYTES;
    end else begin
      cfg_o.usable = blk_len_q;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dbc_walker.sv =====
// dbc_walker: per-byte record walk, dot-name check and tail check
// depends on dbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbc_walker
  import dbc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       clear_i,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output logic            last_o,
  output res_t            res_o
);

  logic [15:0] pos_q;
  logic [15:0] rs_q, rs_d;
  logic [15:0] next_q, next_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic        inode_q, inode_d;
  logic [1:0]  nl_q, nl_d;
  logic [16:0] ncp_q, ncp_d;
  fault_e      fault_q, fault_d;
  logic        snd_q, snd_d;

  logic [16:0] pos17, use17, rs_hdr, rs_len, rs_name;
  logic [15:0] rel_full, len_full, tail_base, t_full;
  logic [2:0]  rel;
  logic [3:0]  t;
  logic        in_hdr, in_tail, bad;
  fault_e      kind;

  always_comb begin
    pos17     = {1'b0, pos_q};
    use17     = {1'b0, cfg_i.usable};
    rel_full  = pos_q - rs_q;
    rel       = rel_full[2:0];
    len_full  = {byte_i, len_lo_q};
    rs_hdr    = {1'b0, rs_q} + {1'b0, HDR_BYTES};
    rs_len    = {1'b0, rs_q} + {1'b0, len_full};
    rs_name   = rs_hdr + {9'd0, byte_i};
    tail_base = cfg_i.blk_len - TAIL_BYTES;
    t_full    = pos_q - tail_base;
    t         = t_full[3:0];
    in_hdr    = (fault_q == FAULT_NONE) && (rs_q < cfg_i.usable) &&
                (pos_q >= rs_q) && (rel_full < HDR_BYTES);
    in_tail   = cfg_i.tail_present && !cfg_i.too_small && (pos_q >= tail_base);
    last_o    = (pos17 + 17'd1) >= {1'b0, cfg_i.blk_len};

    rs_d     = rs_q;
    next_d   = next_q;
    len_lo_d = len_lo_q;
    inode_d  = inode_q;
    nl_d     = nl_q;
    ncp_d    = ncp_q;
    fault_d  = fault_q;
    snd_d    = snd_q;

    // pending dot-name byte
    if ((nl_q != 2'd0) && (pos17 == ncp_q)) begin
      if (byte_i != DOT_CHAR) begin
        snd_d = 1'b1;
        nl_d  = 2'd0;
      end else if (nl_q == 2'd2) begin
        nl_d  = 2'd1;
        ncp_d = ncp_q + 17'd1;
      end else begin
        nl_d = 2'd0;
      end
    end

    // record header walk
    if (in_hdr) begin
      case (rel)
        3'd0: begin
          if (rs_hdr > use17) fault_d = FAULT_REC_LEN;
          inode_d = (byte_i != 8'd0);
        end
        3'd1, 3'd2, 3'd3: begin
          if (byte_i != 8'd0) inode_d = 1'b1;
        end
        3'd4: len_lo_d = byte_i;
        3'd5: begin
          if ((len_full < HDR_BYTES) || (len_full[1:0] != 2'd0) || (rs_len > use17)) begin
            fault_d = FAULT_REC_LEN;
          end else begin
            next_d = rs_len[15:0];
          end
        end
        3'd6: begin
          if (inode_q && (rs_name > use17)) begin
            fault_d = FAULT_NAME;
          end else begin
            if (inode_q) begin
              if ((byte_i == 8'd1) || (byte_i == 8'd2)) begin
                nl_d  = byte_i[1:0];
                ncp_d = rs_hdr;
              end else begin
                snd_d = 1'b1;
              end
            end
            rs_d = next_q;
          end
        end
        default: ;
      endcase
    end

    // tail header
    bad = 1'b0;
    if (in_tail) begin
      case (t)
        4'd0, 4'd1, 4'd2, 4'd3: bad = (byte_i != 8'd0);
        4'd4:                   bad = (byte_i != TAIL_BYTES[7:0]);
        4'd5, 4'd6:             bad = (byte_i != 8'd0);
        4'd7:                   bad = (byte_i != TAIL_TYPE);
        default:                bad = 1'b0;
      endcase
    end
    if (bad && (fault_d == FAULT_NONE)) fault_d = FAULT_TAIL;

    kind                   = cfg_i.too_small ? FAULT_SMALL : fault_d;
    res_o.block_ok         = (kind == FAULT_NONE);
    res_o.fault_kind       = kind;
    res_o.only_dot_entries = (kind == FAULT_NONE) && !snd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 16'd0;
      rs_q     <= 16'd0;
      next_q   <= 16'd0;
      len_lo_q <= 8'd0;
      inode_q  <= 1'b0;
      nl_q     <= 2'd0;
      ncp_q    <= 17'd0;
      fault_q  <= FAULT_NONE;
      snd_q    <= 1'b0;
    end else if (clear_i || (step_i && last_o)) begin
      pos_q    <= 16'd0;
      rs_q     <= 16'd0;
      next_q   <= 16'd0;
      len_lo_q <= 8'd0;
      inode_q  <= 1'b0;
      nl_q     <= 2'd0;
      ncp_q    <= 17'd0;
      fault_q  <= FAULT_NONE;
      snd_q    <= 1'b0;
    end else if (step_i) begin
      pos_q    <= pos_q + 16'd1;
      rs_q     <= rs_d;
      next_q   <= next_d;
      len_lo_q <= len_lo_d;
      inode_q  <= inode_d;
      nl_q     <= nl_d;
      ncp_q    <= ncp_d;
      fault_q  <= fault_d;
      snd_q    <= snd_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dir_block_checker.sv =====
// dir_block_checker: structural check of a linear directory block, one byte a request
// result: the block's last byte passes the byte register, then its verdict is stored in the result register
// throughput: one byte per cycle, unless a block's last byte waits on an unaccepted result; the
//   single-pass walker sits between the byte register and the result register
// reset: asynchronous active low; block size 4096, no tail, walk at offset 0
// depends on dbc_pkg, dbc_if, dbc_cfg_regs, dbc_walker
`timescale 1ns / 1ps
`default_nettype none

module dir_block_checker
  import dbc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  dbc_byte_if.sink         byte_if_i,
  dbc_res_if.source        res_if_o
);

  cfg_t       cfg;
  res_t       res, res_q;
  logic       byte_vld_q;
  logic [7:0] byte_q;
  logic       out_vld_q;
  logic       last;
  logic       fire;

  dbc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dbc_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .clear_i (cfg_we_i),
    .step_i  (fire),
    .byte_i  (byte_q),
    .last_o  (last),
    .res_o   (res)
  );

  assign fire            = byte_vld_q && (!last || !out_vld_q || res_if_o.ready);
  assign byte_if_i.ready = !byte_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (byte_if_i.valid && byte_if_i.ready) begin
      byte_vld_q <= 1'b1;
    end else if (fire) begin
      byte_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_if_i.valid && byte_if_i.ready) begin
      byte_q <= byte_if_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && last) begin
      out_vld_q <= 1'b1;
    end else if (res_if_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && last) begin
      res_q <= res;
    end
  end

  assign res_if_o.valid            = out_vld_q;
  assign res_if_o.block_ok         = res_q.block_ok;
  assign res_if_o.fault_kind       = res_q.fault_kind;
  assign res_if_o.only_dot_entries = res_q.only_dot_entries;

endmodule

`default_nettype wire

// ===== bench/dbc_verdict_checker.sv =====
// dbc_verdict_checker: predicts the verdict of each directory block and compares it
// with the result channel; depends on dbc_pkg and dbc_if
`timescale 1ns / 1ps

module dbc_verdict_checker
  import dbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  dbc_byte_if         byte_ch_i,
  dbc_res_if          res_ch_i,
  output int          mismatch_count_o,
  output int          results_due_o
);

  logic [15:0] blk_size;
  logic        tail_on;

  logic [15:0] walk_pos;
  logic [15:0] rec_start;
  logic [16:0] rec_next;
  logic [15:0] rec_len;
  logic        live_rec;
  logic [7:0]  dot_pending;
  logic [16:0] dot_pos;
  logic        non_dot_seen;
  fault_e      fault_q;

  res_t due_verdicts[$];
  int   mismatches;

  task automatic clear_walk();
    walk_pos     = '0;
    rec_start    = '0;
    rec_next     = '0;
    rec_len      = '0;
    live_rec     = 1'b0;
    dot_pending  = '0;
    dot_pos      = '0;
    non_dot_seen = 1'b0;
    fault_q      = FAULT_NONE;
  endtask

  task automatic walk_byte(input logic [7:0] b);
    int unsigned p, bs, use_end, rs, rl, rel, t;
    logic        too_short, bad;
    res_t        v;
    bs        = blk_size;
    too_short = (bs < HDR_BYTES) || (tail_on && bs < MIN_TAIL_BLOCK);
    use_end   = too_short ? 0 : (tail_on ? bs - TAIL_BYTES : bs);
    p         = walk_pos;
    rs        = rec_start;

    // first or second name byte of a live entry
    if (dot_pending != 0 && p == dot_pos) begin
      if (b != DOT_CHAR) begin
        non_dot_seen = 1'b1;
        dot_pending  = '0;
      end else if (dot_pending == 8'd2) begin
        dot_pending = 8'd1;
        dot_pos     = dot_pos + 17'd1;
      end else begin
        dot_pending = '0;
      end
    end

    if (fault_q == FAULT_NONE && rs < use_end && p >= rs && p - rs < HDR_BYTES) begin
      rel = p - rs;
      case (rel)
        0: begin
          if (rs + HDR_BYTES > use_end) fault_q = FAULT_REC_LEN;
          live_rec = (b != 8'd0);
        end
        1, 2, 3: begin
          if (b != 8'd0) live_rec = 1'b1;
        end
        4: begin
          rec_len = {8'd0, b};
        end
        5: begin
          rec_len = {b, rec_len[7:0]};
          rl      = rec_len;
          if (rl < HDR_BYTES || (rl % 4) != 0 || rs + rl > use_end) begin
            fault_q = FAULT_REC_LEN;
          end else begin
            rec_next = 17'(rs + rl);
          end
        end
        6: begin
          if (live_rec && rs + HDR_BYTES + b > use_end) begin
            fault_q = FAULT_NAME;
          end else begin
            if (live_rec) begin
              if (b == 8'd1 || b == 8'd2) begin
                dot_pending = b;
                dot_pos     = 17'(rs + HDR_BYTES);
              end else begin
                non_dot_seen = 1'b1;
              end
            end
            rec_start = rec_next[15:0];
          end
        end
        default: ;
      endcase
    end

    // checksum tail header
    if (tail_on && !too_short && p >= bs - TAIL_BYTES) begin
      t   = p - (bs - TAIL_BYTES);
      bad = 1'b0;
      if (t < 4) bad = (b != 8'd0);
      else if (t == 4) bad = (b != TAIL_BYTES[7:0]);
      else if (t == 5 || t == 6) bad = (b != 8'd0);
      else if (t == 7) bad = (b != TAIL_TYPE);
      if (bad && fault_q == FAULT_NONE) fault_q = FAULT_TAIL;
    end

    if (p + 1 >= bs) begin
      v.fault_kind       = too_short ? FAULT_SMALL : fault_q;
      v.block_ok         = (v.fault_kind == FAULT_NONE);
      v.only_dot_entries = v.block_ok && !non_dot_seen;
      due_verdicts.push_back(v);
      clear_walk();
    end else begin
      walk_pos = 16'(p + 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      blk_size = BLOCK_SIZE_RST;
      tail_on  = 1'b0;
      clear_walk();
      due_verdicts.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_BLOCK_SIZE) blk_size = cfg_wdata_i;
        else if (cfg_idx_i == CFG_TAIL_PRESENT) tail_on = cfg_wdata_i[0];
        clear_walk();
      end
      if (byte_ch_i.valid && byte_ch_i.ready) walk_byte(byte_ch_i.data_byte);
      if (res_ch_i.valid && res_ch_i.ready) begin
        got.block_ok         = res_ch_i.block_ok;
        got.fault_kind       = res_ch_i.fault_kind;
        got.only_dot_entries = res_ch_i.only_dot_entries;
        if (due_verdicts.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with none due: ok=%0d kind=%0d dots=%0d", $realtime,
                     got.block_ok, got.fault_kind, got.only_dot_entries);
          mismatches++;
        end else begin
          want = due_verdicts.pop_front();
          if (got.block_ok !== want.block_ok || got.fault_kind !== want.fault_kind ||
              got.only_dot_entries !== want.only_dot_entries) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected ok=%0d kind=%0d dots=%0d, got ok=%0d kind=%0d dots=%0d",
                       $realtime, want.block_ok, want.fault_kind, want.only_dot_entries,
                       got.block_ok, got.fault_kind, got.only_dot_entries);
            mismatches++;
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    results_due_o    <= due_verdicts.size();
  end

endmodule

// ===== bench/dir_block_checker_tb.sv =====
// dir_block_checker_tb: streams directory blocks of many sizes and shapes into the
// checker and gives the verdict; depends on dbc_pkg, dbc_if, dbc_verdict_checker
`timescale 1ns / 1ps

module dir_block_checker_tb;
  import dbc_pkg::*;

  typedef enum int {BLK_ANY, BLK_CLEAN, BLK_DAMAGED, BLK_NOISE, BLK_BOTH_BAD} blk_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_wdata;

  dbc_byte_if byte_ch();
  dbc_res_if  res_ch();

  int mismatch_count;
  int results_due;

  bit [7:0] blk_bytes[$];
  int       burst_left;
  int       bytes_sent;
  int       stall_left;
  int       stall_mode;
  int       mode_left;

  dir_block_checker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .byte_if_i  (byte_ch),
    .res_if_o   (res_ch)
  );

  dbc_verdict_checker u_verdict_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .byte_ch_i       (byte_ch),
    .res_ch_i        (res_ch),
    .mismatch_count_o(mismatch_count),
    .results_due_o   (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side stalls on its own pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
      mode_left  = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      if (stall_left != 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        case (stall_mode)
          1: stall_left = $urandom_range(0, 1);
          2: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 20);
          3: stall_left = $urandom_range(0, 3);
          default: ;
        endcase
      end
    end
  end

  task automatic build_block(input int unsigned bs, input bit tail, input blk_kind_e kind);
    int unsigned nbytes, use_end, pos, room, len, nl, w, cap, idx, base;
    bit          live, dots, dot_name;
    nbytes = (bs == 0) ? 1 : bs;
    blk_bytes.delete();
    repeat (nbytes) blk_bytes.push_back(8'($urandom_range(0, 255)));
    if (kind == BLK_NOISE || bs < HDR_BYTES || (tail && bs < MIN_TAIL_BLOCK)) return;
    use_end = tail ? bs - TAIL_BYTES : bs;
    dots    = $urandom_range(0, 1);
    pos     = 0;
    while (pos + HDR_BYTES <= use_end) begin
      room = use_end - pos;
      if (room < 16 || $urandom_range(0, 3) == 0) begin
        len = room & ~32'd3;
      end else begin
        cap = room / 4;
        if (cap > 24) cap = 24;
        len = 4 * $urandom_range(2, cap);
      end
      live = ($urandom_range(0, 3) != 0);
      w    = live ? $urandom : 0;
      if (live && w == 0) w = 1;
      dot_name = live && (dots || $urandom_range(0, 2) == 0);
      if (dot_name) begin
        nl = $urandom_range(1, 2);
      end else begin
        cap = len - HDR_BYTES;
        if (cap > 255) cap = 255;
        nl = $urandom_range(0, live ? cap : 255);
      end
      for (int i = 0; i < 4; i++) blk_bytes[pos + i] = w[8*i +: 8];
      blk_bytes[pos + 4] = len[7:0];
      blk_bytes[pos + 5] = len[15:8];
      blk_bytes[pos + 6] = nl[7:0];
      if (dot_name) begin
        for (int i = 0; i < nl; i++)
          if (pos + HDR_BYTES + i < nbytes) blk_bytes[pos + HDR_BYTES + i] = DOT_CHAR;
      end
      pos += len;
    end
    if (tail) begin
      base = bs - TAIL_BYTES;
      for (int i = 0; i < 4; i++) blk_bytes[base + i] = 8'd0;
      blk_bytes[base + 4] = TAIL_BYTES[7:0];
      blk_bytes[base + 5] = 8'd0;
      blk_bytes[base + 6] = 8'd0;
      blk_bytes[base + 7] = TAIL_TYPE;
    end
    if (kind == BLK_DAMAGED) begin
      case ($urandom_range(0, 3))
        0: blk_bytes[4] = 8'($urandom_range(0, 255));
        1: blk_bytes[6] = 8'hFF;
        2: begin
          idx = tail ? bs - TAIL_BYTES + $urandom_range(0, 7) : $urandom_range(0, nbytes - 1);
          blk_bytes[idx] = 8'($urandom_range(0, 255));
        end
        default: blk_bytes[$urandom_range(0, nbytes - 1)] = 8'($urandom_range(0, 255));
      endcase
    end else if (kind == BLK_BOTH_BAD) begin
      // record fault early, tail fault later: the record fault must win
      blk_bytes[4] = 8'd6;
      blk_bytes[5] = 8'd0;
      if (tail) blk_bytes[bs - TAIL_BYTES + 7] = 8'd0;
    end
  endtask

  task automatic push_byte(input bit [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) == 0) begin
        byte_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_bytes(input int unsigned cut);
    int unsigned n;
    n = (cut != 0 && cut < blk_bytes.size()) ? cut : blk_bytes.size();
    for (int unsigned i = 0; i < n; i++) push_byte(blk_bytes[i]);
  endtask

  // quiet the sender until every verdict is back, then let the pipeline drain
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_config(input int unsigned bs, input bit tail);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_BLOCK_SIZE;
    cfg_wdata <= bs[15:0];
    @(posedge clk_i);
    cfg_idx   <= CFG_TAIL_PRESENT;
    cfg_wdata <= {15'd0, tail};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned bs, input bit tail, input int nblocks,
                           input blk_kind_e fixed_kind, input int unsigned cut);
    int        r;
    blk_kind_e kind;
    settle();
    write_config(bs, tail);
    repeat (nblocks) begin
      kind = fixed_kind;
      if (kind == BLK_ANY) begin
        r    = $urandom_range(0, 9);
        kind = (r < 7) ? BLK_CLEAN : (r < 9) ? BLK_DAMAGED : BLK_NOISE;
      end
      build_block(bs, tail, kind);
      send_bytes(cut);
    end
  endtask

  initial begin
    int unsigned bs;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_BLOCK_SIZE;
    cfg_wdata         = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    burst_left        = 0;
    bytes_sent        = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // a block under the reset settings, cut short by a register write
    build_block(BLOCK_SIZE_RST, 1'b0, BLK_CLEAN);
    send_bytes(40);

    run_phase(8, 1'b0, 3, BLK_ANY, 0);
    run_phase(0, 1'b0, 3, BLK_ANY, 0);
    run_phase(1, 1'b1, 2, BLK_ANY, 0);
    run_phase(7, 1'b0, 2, BLK_ANY, 0);
    run_phase(19, 1'b1, 2, BLK_ANY, 0);
    run_phase(20, 1'b1, 3, BLK_CLEAN, 0);
    run_phase(32, 1'b1, 2, BLK_BOTH_BAD, 0);
    run_phase(48, 1'b0, 3, BLK_DAMAGED, 0);
    run_phase(30, 1'b0, 2, BLK_CLEAN, 0);
    run_phase(65535, 1'b1, 1, BLK_CLEAN, 100);

    while (bytes_sent < 800) begin
      case ($urandom_range(0, 9))
        0:       bs = $urandom_range(0, 24);
        1, 2:    bs = $urandom_range(96, 160);
        default: bs = $urandom_range(8, 96);
      endcase
      if (bs >= HDR_BYTES && $urandom_range(0, 3) != 0) bs = bs & ~32'd3;
      run_phase(bs, 1'($urandom_range(0, 1)), $urandom_range(1, 3), BLK_ANY, 0);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("** dir_block_checker: PASSED **");
    end else begin
      $display("** dir_block_checker: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("** dir_block_checker: FAILED **");
    $finish;
  end

endmodule

// ===== dir_block_checker.f =====
hdl/dbc_pkg.sv
hdl/dbc_if.sv
hdl/dbc_cfg_regs.sv
hdl/dbc_walker.sv
hdl/dir_block_checker.sv
bench/dbc_verdict_checker.sv
bench/dir_block_checker_tb.sv
